// File: hw/rtl/bmp_stream_decoder_assert.svh
// assertion macros used by the checker file
`ifndef BMP_STREAM_DECODER_ASSERT_SVH
`define BMP_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BMP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define BMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/bmpd_pkg.sv
// shared types and constants of the bmp stream decoder
package bmpd_pkg;

  // result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_SIZE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_HDR_SIZE  = 3'd2;
  localparam logic [2:0] ERR_DEPTH     = 3'd3;
  localparam logic [2:0] ERR_INDEX     = 3'd4;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd5;

  // color sources of a result
  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_DIRECT = 2'd1;
  localparam logic [1:0] SRC_PAL0   = 2'd2;
  localparam logic [1:0] SRC_PAL1   = 2'd3;

  // header byte positions where a field completes
  localparam logic [5:0] POS_SIG_B     = 6'd0;
  localparam logic [5:0] POS_SIG_M     = 6'd1;
  localparam logic [5:0] POS_HDR_SIZE  = 6'd17;
  localparam logic [5:0] POS_OS2_W     = 6'd19;
  localparam logic [5:0] POS_OS2_H     = 6'd21;
  localparam logic [5:0] POS_OS2_DEPTH = 6'd25;
  localparam logic [5:0] POS_WIN_W     = 6'd21;
  localparam logic [5:0] POS_WIN_H     = 6'd25;
  localparam logic [5:0] POS_WIN_DEPTH = 6'd29;
  localparam logic [5:0] POS_WIN_COUNT = 6'd49;
  localparam logic [5:0] POS_WIN_END   = 6'd53;

  localparam logic [31:0] HDR_OS2 = 32'd12;
  localparam logic [31:0] HDR_WIN = 32'd40;
  localparam logic [7:0]  SIG_B   = 8'h42;
  localparam logic [7:0]  SIG_M   = 8'h4d;

  typedef enum logic [2:0] {
    PH_HEAD, PH_PAL, PH_PIX, PH_PAD, PH_DONE, PH_FAIL
  } phase_t;

  // parser state
  typedef struct packed {
    phase_t      phase;
    logic [5:0]  hcnt;
    logic [31:0] fshift;
    logic [16:0] width;
    logic [16:0] height;
    logic [4:0]  depth;
    logic        top_down;
    logic        short_hdr;
    logic [8:0]  pal_count;
    logic [8:0]  pal_fill;
    logic [1:0]  ebi;
    logic [16:0] col;
    logic [16:0] row;
    logic [17:0] rbc;
    logic [1:0]  pad;
    logic [15:0] hold;
  } state_t;

  // one pending result
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [2:0]  err;
    logic        last;
    logic [1:0]  src;
  } res_t;

endpackage

// File: hw/rtl/bmp_stream_decoder.sv
// bmp stream decoder top level
// an accepted byte's results pass through the result stage registers, then the output register
// input: one byte per cycle while the output is not stalled; a 4 bpp byte with two pixels holds
// the input back, since the result stage drains one item per cycle when the output is free
// palette reads use a registered memory with two read ports addressed by the incoming byte
// reset: synchronous active-low rst_n clears parser, pipeline and output valid
module bmp_stream_decoder #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  // x_pos, y_pos, red, green, blue, image_width, image_height, error_code, zero fill
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last
);
  import bmpd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  state_t      st_r, st_nxt, cur;
  res_t        slot_nxt [2];
  res_t        s1_slot_r [2];
  logic [1:0]  n_nxt, s1_cnt_r;
  logic        s1_ptr_r;
  logic [23:0] rgb_nxt, s1_rgb_r;
  logic [12:0] s1_w_r, s1_h_r;
  logic [23:0] pal_q0_r, pal_q1_r;
  logic [23:0] palette [PALETTE_DEPTH];
  logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
  logic        wr_en;
  logic        accept, out_free, move;
  logic        out_valid_r;
  logic [79:0] out_data_r;
  logic [1:0]  out_kind_r;
  logic        out_last_r;
  res_t        cur_res;
  logic [23:0] cur_rgb;

  // parser next state and results of one byte
  always_comb begin
    logic [31:0] fs, v;
    logic [15:0] v16;
    logic [7:0]  b;
    logic        do_finish, do_start, bad, empty;
    logic [17:0] rb, rbc_inc;
    logic [8:0]  cnt;
    logic [7:0]  idx0, idx1;
    logic [16:0] yv;
    b = in_tdata;
    cur = in_tuser ? state_t'('0) : st_r;
    st_nxt = cur;
    n_nxt = 2'd0;
    slot_nxt[0] = '0;
    slot_nxt[1] = '0;
    rgb_nxt = '0;
    rd_addr0 = '0;
    rd_addr1 = '0;
    wr_addr = '0;
    wr_en = 1'b0;
    do_finish = 1'b0;
    do_start = 1'b0;
    fs = '0;
    v = '0;
    v16 = '0;
    bad = 1'b0;
    empty = 1'b0;
    cnt = '0;
    yv = '0;
    idx0 = '0;
    idx1 = '0;
    rb = '0;
    rbc_inc = '0;
    unique case (cur.phase)
      PH_HEAD: begin
        fs = {b, cur.fshift[31:8]};
        st_nxt.fshift = fs;
        st_nxt.hcnt = cur.hcnt + 6'd1;
        v16 = fs[31:16];
        if (cur.hcnt == POS_SIG_B) begin
          bad = (b != SIG_B);
          slot_nxt[0].err = ERR_SIGNATURE;
        end else if (cur.hcnt == POS_SIG_M) begin
          bad = (b != SIG_M);
          slot_nxt[0].err = ERR_SIGNATURE;
        end else if (cur.hcnt == POS_HDR_SIZE) begin
          if (fs == HDR_OS2) st_nxt.short_hdr = 1'b1;
          else if (fs == HDR_WIN) st_nxt.short_hdr = 1'b0;
          else bad = 1'b1;
          slot_nxt[0].err = ERR_HDR_SIZE;
        end else if (cur.short_hdr) begin
          if (cur.hcnt == POS_OS2_W) begin
            bad = ({16'd0, v16} > 32'(MAX_WIDTH));
            slot_nxt[0].err = ERR_TOO_LARGE;
            st_nxt.width = {1'b0, v16};
          end else if (cur.hcnt == POS_OS2_H) begin
            bad = ({16'd0, v16} > 32'(MAX_HEIGHT));
            slot_nxt[0].err = ERR_TOO_LARGE;
            st_nxt.height = {1'b0, v16};
          end else if (cur.hcnt == POS_OS2_DEPTH) begin
            bad = !(v16 == 16'd4 || v16 == 16'd8 || v16 == 16'd24);
            slot_nxt[0].err = ERR_DEPTH;
            st_nxt.depth = v16[4:0];
            do_finish = !bad;
          end
        end else begin
          if (cur.hcnt == POS_WIN_W) begin
            bad = (fs > 32'(MAX_WIDTH));
            slot_nxt[0].err = ERR_TOO_LARGE;
            st_nxt.width = fs[16:0];
          end else if (cur.hcnt == POS_WIN_H) begin
            v = fs;
            if (fs[31]) begin
              st_nxt.top_down = 1'b1;
              v = 32'd0 - fs;
            end
            bad = (v > 32'(MAX_HEIGHT));
            slot_nxt[0].err = ERR_TOO_LARGE;
            st_nxt.height = v[16:0];
          end else if (cur.hcnt == POS_WIN_DEPTH) begin
            bad = !(v16 == 16'd4 || v16 == 16'd8 || v16 == 16'd24);
            slot_nxt[0].err = ERR_DEPTH;
            st_nxt.depth = v16[4:0];
          end else if (cur.hcnt == POS_WIN_COUNT) begin
            st_nxt.pal_count = (fs > 32'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH + 1) : fs[8:0];
          end else if (cur.hcnt == POS_WIN_END) begin
            do_finish = 1'b1;
          end
        end
        if (bad) begin
          n_nxt = 2'd1;
          slot_nxt[0].kind = KIND_ERROR;
          slot_nxt[0].last = 1'b1;
          st_nxt.phase = PH_FAIL;
        end else begin
          slot_nxt[0].err = ERR_NONE;
        end
      end
      PH_PAL: begin
        case (cur.ebi)
          2'd0: begin
            st_nxt.hold = {8'd0, b};
            st_nxt.ebi = 2'd1;
          end
          2'd1: begin
            st_nxt.hold = {b, cur.hold[7:0]};
            st_nxt.ebi = 2'd2;
          end
          default: begin
            if (cur.ebi == 2'd2) begin
              wr_en = (cur.pal_fill < 9'(PALETTE_DEPTH));
              wr_addr = cur.pal_fill[AW-1:0];
            end
            if (cur.ebi == 2'd2 && !cur.short_hdr) begin
              st_nxt.ebi = 2'd3;
            end else begin
              st_nxt.ebi = 2'd0;
              st_nxt.pal_fill = cur.pal_fill + 9'd1;
              do_start = (cur.pal_fill + 9'd1 >= cur.pal_count);
            end
          end
        endcase
      end
      PH_PIX: begin
        if (cur.depth == 5'd24) rb = {cur.width, 1'b0} + {1'b0, cur.width};
        else if (cur.depth == 5'd8) rb = {1'b0, cur.width};
        else rb = ({1'b0, cur.width} + 18'd1) >> 1;
        yv = cur.top_down ? cur.row : cur.height - 17'd1 - cur.row;
        slot_nxt[0].y = yv[11:0];
        slot_nxt[1].y = yv[11:0];
        slot_nxt[0].x = cur.col[11:0];
        slot_nxt[0].last = ({1'b0, cur.col} + 18'd1 == {1'b0, cur.width}) &&
                           ({1'b0, cur.row} + 18'd1 == {1'b0, cur.height});
        slot_nxt[1].x = 12'(cur.col + 17'd1);
        slot_nxt[1].last = ({1'b0, cur.col} + 18'd2 == {1'b0, cur.width}) &&
                           ({1'b0, cur.row} + 18'd1 == {1'b0, cur.height});
        idx0 = (cur.depth == 5'd8) ? b : {4'd0, b[7:4]};
        idx1 = {4'd0, b[3:0]};
        rd_addr0 = AW'(idx0);
        rd_addr1 = AW'(idx1);
        if (cur.depth == 5'd24) begin
          case (cur.ebi)
            2'd0: begin
              st_nxt.hold = {8'd0, b};
              st_nxt.ebi = 2'd1;
            end
            2'd1: begin
              st_nxt.hold = {b, cur.hold[7:0]};
              st_nxt.ebi = 2'd2;
            end
            default: begin
              n_nxt = 2'd1;
              slot_nxt[0].src = SRC_DIRECT;
              rgb_nxt = {b, cur.hold};
              st_nxt.col = cur.col + 17'd1;
              st_nxt.ebi = 2'd0;
            end
          endcase
        end else begin
          n_nxt = 2'd1;
          if ({1'b0, idx0} >= cur.pal_count || {1'b0, idx0} >= 9'(PALETTE_DEPTH)) begin
            bad = 1'b1;
            slot_nxt[0] = '0;
            slot_nxt[0].kind = KIND_ERROR;
            slot_nxt[0].err = ERR_INDEX;
            slot_nxt[0].last = 1'b1;
          end else begin
            slot_nxt[0].src = SRC_PAL0;
            st_nxt.col = cur.col + 17'd1;
            if (cur.depth != 5'd8 && ({1'b0, cur.col} + 18'd1 < {1'b0, cur.width})) begin
              n_nxt = 2'd2;
              if ({1'b0, idx1} >= cur.pal_count || {1'b0, idx1} >= 9'(PALETTE_DEPTH)) begin
                bad = 1'b1;
                slot_nxt[1] = '0;
                slot_nxt[1].kind = KIND_ERROR;
                slot_nxt[1].err = ERR_INDEX;
                slot_nxt[1].last = 1'b1;
              end else begin
                slot_nxt[1].src = SRC_PAL1;
                st_nxt.col = cur.col + 17'd2;
              end
            end
          end
        end
        if (bad) begin
          st_nxt.phase = PH_FAIL;
        end else begin
          rbc_inc = cur.rbc + 18'd1;
          if (rbc_inc >= rb) begin
            st_nxt.rbc = '0;
            st_nxt.col = '0;
            st_nxt.ebi = 2'd0;
            if ({1'b0, cur.row} + 18'd1 >= {1'b0, cur.height}) begin
              st_nxt.phase = PH_DONE;
            end else begin
              st_nxt.row = cur.row + 17'd1;
              if (rb[1:0] != 2'd0) begin
                st_nxt.pad = 2'd0 - rb[1:0];
                st_nxt.phase = PH_PAD;
              end
            end
          end else begin
            st_nxt.rbc = rbc_inc;
          end
        end
      end
      PH_PAD: begin
        st_nxt.pad = cur.pad - 2'd1;
        if (cur.pad == 2'd1) st_nxt.phase = PH_PIX;
      end
      default: begin
        st_nxt = cur;
      end
    endcase
    // end of header: palette size (or a too-large error) or straight to pixels
    if (do_finish) begin
      if (st_nxt.depth == 5'd24) begin
        do_start = 1'b1;
      end else begin
        cnt = st_nxt.pal_count;
        if (st_nxt.short_hdr || cnt == 9'd0) cnt = (st_nxt.depth == 5'd4) ? 9'd16 : 9'd256;
        st_nxt.pal_count = cnt;
        if (cnt > 9'(PALETTE_DEPTH)) begin
          n_nxt = 2'd1;
          slot_nxt[0].kind = KIND_ERROR;
          slot_nxt[0].err = ERR_TOO_LARGE;
          slot_nxt[0].last = 1'b1;
          st_nxt.phase = PH_FAIL;
        end else begin
          st_nxt.pal_fill = '0;
          st_nxt.ebi = 2'd0;
          st_nxt.phase = PH_PAL;
        end
      end
    end
    // size result and start of pixel data, or done for an empty image
    if (do_start) begin
      empty = (st_nxt.width == '0) || (st_nxt.height == '0);
      st_nxt.col = '0;
      st_nxt.row = '0;
      st_nxt.rbc = '0;
      st_nxt.ebi = 2'd0;
      st_nxt.phase = empty ? PH_DONE : PH_PIX;
      n_nxt = 2'd1;
      slot_nxt[0] = '0;
      slot_nxt[0].kind = KIND_SIZE;
      slot_nxt[0].last = empty;
    end
  end

  // handshake between input, result stage and output register
  assign out_free  = !out_valid_r || out_tready;
  assign move      = (s1_cnt_r != 2'd0) && out_free;
  assign in_tready = (s1_cnt_r == 2'd0) || (s1_cnt_r == 2'd1 && out_free);
  assign accept    = in_tvalid && in_tready;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      s1_cnt_r <= 2'd0;
      s1_ptr_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r <= st_nxt;
        s1_cnt_r <= n_nxt;
        s1_ptr_r <= 1'b0;
      end else if (move) begin
        s1_cnt_r <= s1_cnt_r - 2'd1;
        s1_ptr_r <= 1'b1;
      end
      if (move) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // palette memory, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (accept && wr_en) palette[wr_addr] <= {in_tdata, st_nxt.hold};
    if (accept) begin
      pal_q0_r <= palette[rd_addr0];
      pal_q1_r <= palette[rd_addr1];
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot_r[0] <= slot_nxt[0];
      s1_slot_r[1] <= slot_nxt[1];
      s1_rgb_r <= rgb_nxt;
      s1_w_r <= st_nxt.width[12:0];
      s1_h_r <= st_nxt.height[12:0];
    end
  end

  // pick the next result and its color
  always_comb begin
    cur_res = s1_slot_r[s1_ptr_r];
    case (cur_res.src)
      SRC_DIRECT: cur_rgb = s1_rgb_r;
      SRC_PAL0:   cur_rgb = pal_q0_r;
      SRC_PAL1:   cur_rgb = pal_q1_r;
      default:    cur_rgb = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_kind_r <= cur_res.kind;
      out_last_r <= cur_res.last;
      out_data_r <= {3'd0, cur_res.err,
                     (cur_res.kind == KIND_SIZE) ? s1_h_r : 13'd0,
                     (cur_res.kind == KIND_SIZE) ? s1_w_r : 13'd0,
                     cur_rgb[7:0], cur_rgb[15:8], cur_rgb[23:16],
                     cur_res.y, cur_res.x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hw/rtl/bmpd_checker.sv
// port checker for the bmp stream decoder and its bind
`include "bmp_stream_decoder_assert.svh"

module bmpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import bmpd_pkg::*;

  // a stalled item stays offered
  `BMP_ASSERT_NEXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid)
  // an error item always closes the file
  `BMP_ASSERT_IMPL(a_err_last, out_tvalid && out_tuser == KIND_ERROR, out_tlast)
  // pixel and size items carry no error code
  `BMP_ASSERT_IMPL(a_no_code, out_tvalid && out_tuser != KIND_ERROR, out_tdata[76:74] == ERR_NONE)
  // only defined kinds appear
  `BMP_ASSERT_IMPL(a_kind, out_tvalid, out_tuser == KIND_PIXEL || out_tuser == KIND_SIZE || out_tuser == KIND_ERROR)

endmodule

bind bmp_stream_decoder bmpd_checker u_bmpd_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);

// File: tb/tb_bmp_stream_decoder.sv
// testbench for the bmp stream decoder: bitmap files in, pixel/size/error items checked
`timescale 1ns / 1ps

module tb_bmp_stream_decoder;
  import bmpd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] w;
    logic [12:0] h;
    logic [2:0]  err;
    logic        last;
  } pix_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  bmp_stream_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  pix_item_t   pending_items[$];
  logic [7:0]  file_bytes[$];
  int          mismatch_cnt;
  int          burst_left;
  int          sent_items;

  // decoder shadow state
  phase_t      dec_phase;
  int unsigned hdr_pos, shift_reg, iw, ih, depth, top_down, os2_hdr;
  int unsigned pal_count, pal_fill, ebi, col, row, row_cnt, pad_left, hold;
  logic [23:0] pal_mem [256];

  // clock and reset
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    forever #1 clk = ~clk;
  end

  // overall time limit
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------- prediction ----------------

  function automatic void dec_clear();
    dec_phase = PH_HEAD; hdr_pos = 0; shift_reg = 0; iw = 0; ih = 0; depth = 0;
    top_down = 0; os2_hdr = 0; pal_count = 0; pal_fill = 0; ebi = 0; col = 0;
    row = 0; row_cnt = 0; pad_left = 0; hold = 0;
  endfunction

  function automatic void push_item(logic [1:0] kind, int unsigned x, int unsigned y,
                                    int unsigned rgb, logic [2:0] err, logic last);
    pix_item_t it;
    it.kind = kind;
    it.x = x[11:0];
    it.y = y[11:0];
    it.red = rgb[23:16];
    it.green = rgb[15:8];
    it.blue = rgb[7:0];
    it.w = (kind == KIND_SIZE) ? iw[12:0] : 13'd0;
    it.h = (kind == KIND_SIZE) ? ih[12:0] : 13'd0;
    it.err = err;
    it.last = last;
    pending_items = {pending_items, it};
  endfunction

  function automatic void dec_fail(logic [2:0] code);
    push_item(KIND_ERROR, 0, 0, 0, code, 1'b1);
    dec_phase = PH_FAIL;
  endfunction

  function automatic void begin_image();
    logic empty;
    empty = (iw == 0 || ih == 0);
    col = 0; row = 0; row_cnt = 0; ebi = 0;
    dec_phase = empty ? PH_DONE : PH_PIX;
    push_item(KIND_SIZE, 0, 0, 0, ERR_NONE, empty);
  endfunction

  function automatic void end_header();
    if (depth == 24) begin
      begin_image();
      return;
    end
    if (os2_hdr != 0 || pal_count == 0) pal_count = 1 << depth;
    if (pal_count > 256) begin
      dec_fail(ERR_TOO_LARGE);
      return;
    end
    pal_fill = 0; ebi = 0; dec_phase = PH_PAL;
  endfunction

  function automatic bit depth_ok(int unsigned d);
    return d == 4 || d == 8 || d == 24;
  endfunction

  function automatic void header_byte(int unsigned b);
    int unsigned pos, v;
    pos = hdr_pos;
    shift_reg = (shift_reg >> 8) | (b << 24);
    hdr_pos = (pos + 1) & 63;
    if (pos == POS_SIG_B) begin
      if (b != SIG_B) dec_fail(ERR_SIGNATURE);
      return;
    end
    if (pos == POS_SIG_M) begin
      if (b != SIG_M) dec_fail(ERR_SIGNATURE);
      return;
    end
    if (pos == POS_HDR_SIZE) begin
      if (shift_reg == HDR_OS2) os2_hdr = 1;
      else if (shift_reg == HDR_WIN) os2_hdr = 0;
      else dec_fail(ERR_HDR_SIZE);
      return;
    end
    if (os2_hdr != 0) begin
      v = shift_reg >> 16;
      if (pos == POS_OS2_W) begin
        if (v > 4096) dec_fail(ERR_TOO_LARGE);
        else iw = v;
      end else if (pos == POS_OS2_H) begin
        if (v > 4096) dec_fail(ERR_TOO_LARGE);
        else ih = v;
      end else if (pos == POS_OS2_DEPTH) begin
        if (!depth_ok(v)) dec_fail(ERR_DEPTH);
        else begin
          depth = v;
          end_header();
        end
      end
      return;
    end
    v = shift_reg;
    if (pos == POS_WIN_W) begin
      if (v > 4096) dec_fail(ERR_TOO_LARGE);
      else iw = v;
    end else if (pos == POS_WIN_H) begin
      if (v[31]) begin
        top_down = 1;
        v = 0 - v;
      end
      if (v > 4096) dec_fail(ERR_TOO_LARGE);
      else ih = v;
    end else if (pos == POS_WIN_DEPTH) begin
      if (!depth_ok(v >> 16)) dec_fail(ERR_DEPTH);
      else depth = v >> 16;
    end else if (pos == POS_WIN_COUNT) begin
      pal_count = (v > 256) ? 257 : v;
    end else if (pos == POS_WIN_END) begin
      end_header();
    end
  endfunction

  function automatic void palette_byte(int unsigned b);
    if (ebi == 0) begin
      hold = b; ebi = 1;
      return;
    end
    if (ebi == 1) begin
      hold = hold | (b << 8); ebi = 2;
      return;
    end
    if (ebi == 2) begin
      if (pal_fill < 256) pal_mem[pal_fill] = {b[7:0], hold[15:0]};
      if (os2_hdr == 0) begin
        ebi = 3;
        return;
      end
    end
    ebi = 0;
    pal_fill++;
    if (pal_fill >= pal_count) begin_image();
  endfunction

  function automatic void emit_pixel(int unsigned rgb);
    int unsigned y;
    y = (top_down != 0) ? row : ih - 1 - row;
    push_item(KIND_PIXEL, col, y, rgb, ERR_NONE, (col + 1 == iw) && (row + 1 == ih));
    col++;
  endfunction

  function automatic void emit_index(int unsigned idx);
    if (idx >= pal_count) dec_fail(ERR_INDEX);
    else emit_pixel(pal_mem[idx]);
  endfunction

  function automatic void pixel_byte(int unsigned b);
    int unsigned rb, pad;
    rb = (depth == 24) ? iw * 3 : (depth == 8) ? iw : (iw + 1) / 2;
    if (depth == 24) begin
      if (ebi == 0) begin
        hold = b; ebi = 1;
      end else if (ebi == 1) begin
        hold = hold | (b << 8); ebi = 2;
      end else begin
        emit_pixel({b[7:0], hold[15:0]});
        ebi = 0;
      end
    end else if (depth == 8) begin
      emit_index(b);
    end else begin
      emit_index((b & 8'hf0) >> 4);
      if (dec_phase == PH_FAIL) return;
      if (col < iw) emit_index(b & 8'h0f);
    end
    if (dec_phase == PH_FAIL) return;
    row_cnt++;
    if (row_cnt >= rb) begin
      pad = (4 - (rb & 3)) & 3;
      row_cnt = 0; col = 0; ebi = 0;
      if (row + 1 >= ih) begin
        dec_phase = PH_DONE;
        return;
      end
      row++;
      if (pad != 0) begin
        pad_left = pad;
        dec_phase = PH_PAD;
      end
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic sof);
    if (sof) dec_clear();
    case (dec_phase)
      PH_HEAD: header_byte(b);
      PH_PAL:  palette_byte(b);
      PH_PIX:  pixel_byte(b);
      PH_PAD: begin
        pad_left = (pad_left - 1) & 3;
        if (pad_left == 0) dec_phase = PH_PIX;
      end
      default: ;
    endcase
  endfunction

  // ---------------- driving ----------------

  // one input item, sender bursts and gaps
  task automatic send_item(input logic [7:0] b, input logic sof);
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tuser = sof;
    do @(posedge clk); while (!in_tready);
    predict_byte(b, sof);
    sent_items++;
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_file(input bit with_sof);
    foreach (file_bytes[i]) send_item(file_bytes[i], (i == 0) && with_sof);
  endtask

  task automatic add_byte(input logic [7:0] v);
    file_bytes = {file_bytes, v};
  endtask

  task automatic add_le(input int unsigned v, input int n);
    for (int i = 0; i < n; i++) add_byte(8'(v >> (8 * i)));
  endtask

  function automatic int unsigned pick_index(int unsigned ncol, int bad_pct, int maxv);
    if ($urandom_range(0, 99) < bad_pct) return $urandom_range(0, maxv);
    return $urandom_range(0, ncol - 1);
  endfunction

  // assemble a bitmap file; rows beyond max_rows are left out
  task automatic build_file(input int d, input bit os2, input int unsigned w,
                            input int h, input int unsigned clr, input int bad_pct,
                            input int max_rows);
    int unsigned ah, ncol, rb, pad, hi, lo;
    file_bytes.delete();
    add_byte(SIG_B);
    add_byte(SIG_M);
    add_le($urandom, 4);
    add_le($urandom, 4);
    add_le($urandom, 4);
    if (os2) begin
      add_le(HDR_OS2, 4); add_le(w, 2); add_le(h, 2); add_le(1, 2); add_le(d, 2);
    end else begin
      add_le(HDR_WIN, 4); add_le(w, 4); add_le(h, 4); add_le(1, 2); add_le(d, 2);
      add_le(0, 4); add_le($urandom, 4); add_le($urandom, 4); add_le($urandom, 4);
      add_le(clr, 4); add_le($urandom, 4);
    end
    if (!depth_ok(d) || w > 4096) begin
      add_le($urandom, 4);
      return;
    end
    ah = (h < 0) ? -h : h;
    ncol = (os2 || clr == 0) ? (1 << d) : clr;
    if (d != 24) begin
      if (ncol > 256) return;
      repeat (ncol * (os2 ? 3 : 4)) add_byte(8'($urandom));
    end
    rb = (d == 24) ? w * 3 : (d == 8) ? w : (w + 1) / 2;
    pad = (4 - (rb & 3)) & 3;
    for (int r = 0; r < ah && r < max_rows; r++) begin
      for (int c = 0; c < rb; c++) begin
        if (d == 24) add_byte(8'($urandom));
        else if (d == 8) add_byte(8'(pick_index(ncol, bad_pct, 255)));
        else begin
          hi = pick_index(ncol, bad_pct, 15);
          lo = pick_index(ncol, bad_pct, 15);
          add_byte({hi[3:0], lo[3:0]});
        end
      end
      repeat (pad) add_byte(8'($urandom));
    end
  endtask

  // receiver: its own mix of ready, random and periodic stalls
  int rdy_mode, rdy_len, rdy_cyc;
  always @(negedge clk) begin
    if (rdy_len == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_len = $urandom_range(10, 80);
    end
    rdy_len--;
    rdy_cyc++;
    case (rdy_mode)
      0: out_tready = 1'b1;
      1: out_tready = ($urandom_range(0, 3) != 0);
      2: out_tready = (rdy_cyc % 5) != 0;
      default: out_tready = 1'($urandom_range(0, 1));
    endcase
  end

  // ---------------- checking ----------------

  always @(posedge clk) begin
    pix_item_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[11:0], out_tdata[23:12], out_tdata[31:24],
             out_tdata[39:32], out_tdata[47:40], out_tdata[60:48], out_tdata[73:61],
             out_tdata[76:74], out_tlast};
      if (pending_items.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected item: %h", got);
      end else begin
        want = pending_items.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %h actual %h (kind %0d/%0d x %0d/%0d y %0d/%0d)",
                     want, got, want.kind, got.kind, want.x, got.x, want.y, got.y);
        end
      end
    end
  end

  // ---------------- tests ----------------

  // supported depths, header flavors, odd width, top-down rows
  task automatic test_formats();
    build_file(24, 0, 2, 2, 0, 0, 99);
    send_file(0);
    build_file(24, 1, 3, 2, 0, 0, 99);
    send_file(1);
    build_file(4, 0, 3, -2, 0, 0, 99);
    send_file(1);
    build_file(8, 0, 5, 3, 20, 0, 99);
    send_file(1);
    build_file(4, 1, 1, 1, 0, 0, 99);
    send_file(1);
    // empty image, then trailing bytes are ignored
    build_file(24, 0, 0, 3, 0, 0, 99);
    add_le($urandom, 4);
    send_file(1);
    build_file(8, 0, 4, 0, 3, 0, 99);
    send_file(1);
    // widest and tallest images, both cut short by a restart
    build_file(24, 0, 4096, 1, 0, 0, 0);
    send_file(1);
    build_file(24, 0, 1, 4096, 0, 0, 3);
    send_file(1);
  endtask

  // every error code
  task automatic test_errors();
    send_item(SIG_B, 1);
    send_item(8'h58, 0);
    send_item(8'h00, 0);
    send_item(8'hff, 1);
    build_file(24, 0, 2, 2, 0, 0, 99);
    file_bytes[14] = 8'd20;
    send_file(1);
    build_file(16, 0, 2, 2, 0, 0, 99);
    send_file(1);
    build_file(32, 1, 2, 2, 0, 0, 99);
    send_file(1);
    build_file(24, 0, 4097, 1, 0, 0, 99);
    send_file(1);
    build_file(24, 1, 4097, 1, 0, 0, 99);
    send_file(1);
    build_file(24, 0, 1, 4097, 0, 0, 2);
    send_file(1);
    build_file(24, 1, 1, 4097, 0, 0, 2);
    send_file(1);
    build_file(24, 0, 1, 32'h8000_0000, 0, 0, 2);
    send_file(1);
    build_file(8, 0, 2, 2, 300, 0, 99);
    send_file(1);
    build_file(4, 0, 6, 2, 3, 60, 99);
    send_file(1);
    build_file(8, 0, 6, 2, 1, 60, 99);
    send_file(1);
  endtask

  // random files, mostly well formed, some broken, some noise
  task automatic test_random();
    int sel, d, w, h, cut;
    bit os2;
    int unsigned clr;
    while (sent_items < 1450) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        file_bytes.delete();
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
        send_file(1'($urandom_range(0, 1)));
      end else begin
        d = ($urandom_range(0, 2) == 0) ? 24 : ($urandom_range(0, 1) ? 8 : 4);
        os2 = ($urandom_range(0, 3) == 0) && (d != 8);
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
        h = $urandom_range(0, 4);
        if (!os2 && $urandom_range(0, 2) == 0) h = -h;
        clr = (d == 8 || $urandom_range(0, 2) != 0) ?
              $urandom_range(1, (d == 8) ? 24 : 16) : 0;
        build_file(d, os2, w, h, clr, ($urandom_range(0, 4) == 0) ? 4 : 0, 99);
        if (sel < 18) begin
          // broken: truncated, or a damaged byte
          cut = $urandom_range(1, file_bytes.size());
          if ($urandom_range(0, 1)) file_bytes = file_bytes[0:cut-1];
          else file_bytes[cut-1] = 8'($urandom);
        end else if (sel < 24) begin
          add_le($urandom, $urandom_range(1, 4));
        end
        send_file(1);
      end
    end
  endtask

  initial begin
    mismatch_cnt = 0;
    burst_left = 0;
    sent_items = 0;
    rdy_len = 0;
    rdy_cyc = 0;
    dec_clear();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_formats();
    test_errors();
    test_random();
    in_tvalid = 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && pending_items.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
